@@ rtl/apm_pkg.sv @@
package apm_pkg;

  localparam int PixW     = 32;
  localparam int NumCh    = 3;
  localparam int DivSteps = 32;
  localparam int Latency  = 3 + DivSteps + 1;

  localparam logic [31:0] M1 = 32'h5555_5555;
  localparam logic [31:0] M2 = 32'h3333_3333;
  localparam logic [31:0] M4 = 32'h0f0f_0f0f;
  localparam logic [31:0] M8 = 32'h00ff_00ff;
  localparam logic [31:0] M16 = 32'h0000_ffff;

  localparam logic [1:0] RegRed   = 2'd0;
  localparam logic [1:0] RegGreen = 2'd1;
  localparam logic [1:0] RegBlue  = 2'd2;
  localparam logic [1:0] RegAlpha = 2'd3;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
    logic [PixW-1:0] alpha;
  } apm_masks_t;

  typedef struct packed {
    logic [PixW-1:0] amax;
    logic [PixW-1:0] amask;
    logic [5:0]      sh_r;
    logic [5:0]      sh_g;
    logic [5:0]      sh_b;
    logic            pass;
  } apm_derived_t;

  typedef logic [NumCh-1:0][2*PixW-1:0] apm_lanes_t;

  // trailing zeros by counting the ones below the lowest set bit
  function automatic logic [5:0] apm_tz(input logic [31:0] v);
    logic [31:0] x;
    x = (v & (~v + 32'd1)) - 32'd1;
    x = (x & M1) + ((x >> 1) & M1);
    x = (x & M2) + ((x >> 2) & M2);
    x = (x & M4) + ((x >> 4) & M4);
    x = (x & M8) + ((x >> 8) & M8);
    x = (x & M16) + ((x >> 16) & M16);
    return x[5:0];
  endfunction

endpackage

@@ rtl/apm_cfg.sv @@
module apm_cfg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output apm_pkg::apm_masks_t   masks,
  output apm_pkg::apm_derived_t derived
);
  import apm_pkg::*;

  logic       wr_en;
  logic [1:0] idx;
  logic [5:0] sh_a;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks.red   <= 32'h00ff_0000;
      masks.green <= 32'h0000_ff00;
      masks.blue  <= 32'h0000_00ff;
      masks.alpha <= 32'hff00_0000;
    end else if (wr_en) begin
      case (idx)
        RegRed:   masks.red   <= pwdata;
        RegGreen: masks.green <= pwdata;
        RegBlue:  masks.blue  <= pwdata;
        RegAlpha: masks.alpha <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegRed:   prdata = masks.red;
      RegGreen: prdata = masks.green;
      RegBlue:  prdata = masks.blue;
      RegAlpha: prdata = masks.alpha;
      default:  prdata = '0;
    endcase
  end

  assign sh_a = apm_tz(masks.alpha);

  // values for the later stages, registered from the mask registers
  always_ff @(posedge clk) begin
    derived.amax  <= masks.alpha >> sh_a;
    derived.amask <= masks.alpha;
    derived.sh_r  <= apm_tz(masks.red);
    derived.sh_g  <= apm_tz(masks.green);
    derived.sh_b  <= apm_tz(masks.blue);
    derived.pass  <= (masks.alpha == '0);
  end

endmodule

@@ rtl/apm_front.sv @@
module apm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [31:0]         pixel_in,
  input  apm_pkg::apm_masks_t masks,
  output logic                out_valid,
  output logic [31:0]         pixel_out,
  output apm_pkg::apm_lanes_t products
);
  import apm_pkg::*;

  logic                        v1, v2;
  logic [PixW-1:0]             p1, p2;
  logic [NumCh-1:0][PixW-1:0]  fld;
  logic [PixW-1:0]             alpha;
  logic [NumCh-1:0][PixW-1:0]  fld_next;
  logic [PixW-1:0]             alpha_next;

  // field extraction from the live mask registers
  always_comb begin
    fld_next[0] = (p1 & masks.red)   >> apm_tz(masks.red);
    fld_next[1] = (p1 & masks.green) >> apm_tz(masks.green);
    fld_next[2] = (p1 & masks.blue)  >> apm_tz(masks.blue);
    alpha_next  = (p1 & masks.alpha) >> apm_tz(masks.alpha);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    p1    <= pixel_in;
    p2    <= p1;
    fld   <= fld_next;
    alpha <= alpha_next;
    pixel_out <= p2;
    for (int i = 0; i < NumCh; i++) begin
      products[i] <= 64'(fld[i]) * 64'(alpha);
    end
  end

endmodule

@@ rtl/apm_div_step.sv @@
module apm_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [31:0]         pixel_in,
  input  apm_pkg::apm_lanes_t lanes_in,
  input  logic [31:0]         amax,
  output logic                out_valid,
  output logic [31:0]         pixel_out,
  output apm_pkg::apm_lanes_t lanes_out
);
  import apm_pkg::*;

  apm_lanes_t lanes_next;

  // one restoring step: remainder in the upper half, quotient fills from the bottom
  always_comb begin
    logic [2*PixW:0] sh;
    logic [PixW:0]   top;
    logic [PixW:0]   diff;
    for (int i = 0; i < NumCh; i++) begin
      sh   = {lanes_in[i], 1'b0};
      top  = sh[2*PixW:PixW];
      diff = top - {1'b0, amax};
      if (top >= {1'b0, amax}) begin
        lanes_next[i] = {diff[PixW-1:0], sh[PixW-1:1], 1'b1};
      end else begin
        lanes_next[i] = {top[PixW-1:0], sh[PixW-1:1], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lanes_out <= lanes_next;
    pixel_out <= pixel_in;
  end

endmodule

@@ rtl/alpha_premultiply_bitfield.sv @@
// Premultiplies one 32-bit pixel per clock: each color field selected by its
// mask becomes field * alpha / alpha_max (truncated) and is put back in place,
// the alpha field passes unchanged, bits outside the masks read as zero, and a
// zero alpha mask returns the pixel untouched. An item is taken whenever start
// is high; busy is never raised, so a new pixel may follow every cycle. Each
// result appears on pixel_out with done high for one cycle, after the input,
// field and product registers of the field extraction and 32x32 products,
// then 32 stages of a one-bit-per-stage restoring divider, then the output
// register. The result cannot be held off, so capture it when done is high.
// Mask registers sit at byte addresses 0x0, 0x4, 0x8, 0xC (red, green, blue,
// alpha) and should only be written while no pixel is in flight.
module alpha_premultiply_bitfield (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] pixel_in,
  output logic        done,
  output logic [31:0] pixel_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import apm_pkg::*;

  apm_masks_t                        masks;
  apm_derived_t                      derived;
  logic [DivSteps:0]                 dv;
  logic [DivSteps:0][PixW-1:0]       dp;
  apm_lanes_t                        dl [DivSteps+1];
  logic [PixW-1:0]                   result_next;

  assign busy = 1'b0;

  apm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .masks   (masks),
    .derived (derived)
  );

  apm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .pixel_in  (pixel_in),
    .masks     (masks),
    .out_valid (dv[0]),
    .pixel_out (dp[0]),
    .products  (dl[0])
  );

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    apm_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[g]),
      .pixel_in  (dp[g]),
      .lanes_in  (dl[g]),
      .amax      (derived.amax),
      .out_valid (dv[g+1]),
      .pixel_out (dp[g+1]),
      .lanes_out (dl[g+1])
    );
  end

  always_comb begin
    if (derived.pass) begin
      result_next = dp[DivSteps];
    end else begin
      result_next = (dp[DivSteps] & derived.amask)
                  | (dl[DivSteps][0][PixW-1:0] << derived.sh_r)
                  | (dl[DivSteps][1][PixW-1:0] << derived.sh_g)
                  | (dl[DivSteps][2][PixW-1:0] << derived.sh_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    pixel_out <= result_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(Latency) done)
    else $error("accepted item did not complete on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, Latency))
    else $error("result without a matching item");

  a_div_flow: assert property (@(posedge clk) disable iff (rst)
    dv[0] |-> ##(DivSteps) dv[DivSteps])
    else $error("item lost inside the divider");

endmodule
